[src/ubxfr_pkg.sv]
`timescale 1ns / 1ps

package ubxfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h62;

    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_CLASS,
        ST_ID,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CK_A,
        ST_CK_B,
        ST_EMIT_RD,
        ST_EMIT_WR
    } ubxfr_state_t;

    typedef struct packed {
        logic load_class;
        logic load_id;
        logic load_len_lo;
        logic load_ck_a;
        logic sum_start;
        logic sum_add;
        logic cnt_clear;
        logic cnt_incr;
        logic mem_write;
        logic mem_read;
        logic out_load;
    } ubxfr_cmd_t;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_over;
        logic len_zero;
        logic cnt_end;
        logic ck_ok;
        logic out_free;
    } ubxfr_status_t;

endpackage

[src/ubxfr_ctrl.sv]
`timescale 1ns / 1ps

module ubxfr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ubxfr_pkg::ubxfr_status_t status,
    output ubxfr_pkg::ubxfr_cmd_t    cmd
);
    import ubxfr_pkg::*;

    ubxfr_state_t state_reg;
    ubxfr_state_t state_next;
    logic         acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_WR);
        acc        = in_valid && in_ready;
        case (state_reg)
            ST_SYNC1:
            begin
                if (acc && status.is_sync1)
                begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2:
            begin
                if (acc)
                begin
                    // a mismatch is re-examined as a first sync byte
                    if (status.is_sync2)
                    begin
                        state_next = ST_CLASS;
                    end
                    else if (status.is_sync1)
                    begin
                        state_next = ST_SYNC2;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_CLASS:
            begin
                if (acc)
                begin
                    cmd.load_class = 1'b1;
                    cmd.sum_start  = 1'b1;
                    state_next     = ST_ID;
                end
            end
            ST_ID:
            begin
                if (acc)
                begin
                    cmd.load_id = 1'b1;
                    cmd.sum_add = 1'b1;
                    state_next  = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (acc)
                begin
                    cmd.load_len_lo = 1'b1;
                    cmd.sum_add     = 1'b1;
                    state_next      = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (acc)
                begin
                    cmd.sum_add   = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    if (status.len_over)
                    begin
                        state_next = ST_SYNC1;
                    end
                    else if (status.len_zero)
                    begin
                        state_next = ST_CK_A;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (acc)
                begin
                    cmd.mem_write = 1'b1;
                    cmd.sum_add   = 1'b1;
                    cmd.cnt_incr  = 1'b1;
                    if (status.cnt_end)
                    begin
                        state_next = ST_CK_A;
                    end
                end
            end
            ST_CK_A:
            begin
                if (acc)
                begin
                    cmd.load_ck_a = 1'b1;
                    state_next    = ST_CK_B;
                end
            end
            ST_CK_B:
            begin
                if (acc)
                begin
                    if (status.ck_ok)
                    begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_EMIT_RD:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                // hold the read word until the output slot frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.cnt_incr = 1'b1;
                    state_next   = status.cnt_end ? ST_SYNC1 : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_SYNC1;
            end
        endcase
    end

endmodule

[src/ubxfr_dp.sv]
`timescale 1ns / 1ps

module ubxfr_dp #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ubxfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ubxfr_pkg::BYTE_W-1:0]         cfg_data,
    input  logic [ubxfr_pkg::BYTE_W-1:0]         rx_byte,
    input  ubxfr_pkg::ubxfr_cmd_t                cmd,
    output ubxfr_pkg::ubxfr_status_t             status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [ubxfr_pkg::BYTE_W-1:0]         msg_class,
    output logic [ubxfr_pkg::BYTE_W-1:0]         msg_id,
    output logic [ubxfr_pkg::LEN_W-1:0]          payload_length,
    output logic                                 has_data,
    output logic [ubxfr_pkg::BYTE_W-1:0]         data_byte,
    output logic                                 last
);
    import ubxfr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] class_reg;
    logic [BYTE_W-1:0] id_reg;
    logic [BYTE_W-1:0] len_lo_reg;
    logic [BYTE_W-1:0] ck_a_reg;
    logic [BYTE_W-1:0] sum_a_reg;
    logic [BYTE_W-1:0] sum_b_reg;
    logic [BYTE_W-1:0] sum_a_next;
    logic [BYTE_W-1:0] sum_b_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] payload_mem_reg [MAX_PAYLOAD];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_class_reg;
    logic [BYTE_W-1:0] out_id_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_has_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign len        = len_lo_reg[LEN_W-1:0];
    assign sum_a_next = cmd.sum_start ? rx_byte : BYTE_W'(sum_a_reg + rx_byte);
    assign sum_b_next = cmd.sum_start ? rx_byte : BYTE_W'(sum_b_reg + sum_a_next);
    assign cnt_next   = CNT_W'(cnt_reg + 1'b1);

    always_comb
    begin
        status.is_sync1 = (rx_byte == sync_first_reg);
        status.is_sync2 = (rx_byte == sync_second_reg);
        status.len_over = (rx_byte != '0) || (len_lo_reg > BYTE_W'(MAX_PAYLOAD));
        status.len_zero = (rx_byte == '0) && (len_lo_reg == '0);
        status.cnt_end  = (cnt_next >= len);
        status.ck_ok    = (ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
        status.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_class)
        begin
            class_reg <= rx_byte;
        end
        if (cmd.load_id)
        begin
            id_reg <= rx_byte;
        end
        if (cmd.load_len_lo)
        begin
            len_lo_reg <= rx_byte;
        end
        if (cmd.load_ck_a)
        begin
            ck_a_reg <= rx_byte;
        end
        if (cmd.sum_start || cmd.sum_add)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clear)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_incr)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            payload_mem_reg[cnt_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= payload_mem_reg[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_class_reg <= class_reg;
            out_id_reg    <= id_reg;
            out_len_reg   <= len;
            out_has_reg   <= (len != '0);
            // empty payload gives a single word with zero data
            out_data_reg  <= (len != '0) ? rd_data_reg : '0;
            out_last_reg  <= status.cnt_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign msg_class      = out_class_reg;
    assign msg_id         = out_id_reg;
    assign payload_length = out_len_reg;
    assign has_data       = out_has_reg;
    assign data_byte      = out_data_reg;
    assign last           = out_last_reg;

endmodule

[src/ubx_frame_receiver_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid tready tdata[7:0]         rx_byte
// m_axis    out  tvalid tready tdata tuser tlast  frame payload words
// cfg       in   cfg_we cfg_index cfg_data        sync_first, sync_second
//
// One received byte is taken per cycle while parsing a frame.
// A good frame is read out of the payload RAM one word at a time, each word
// through a RAM read and then an output register load; input stalls during
// that readout. Output back-pressure holds the readout; the last word may
// wait while parsing of the next frame continues. Reset is asynchronous,
// active low.
module ubx_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ubxfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ubxfr_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ubxfr_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] rx_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] msg_class, [15:8] msg_id, [22:16] payload_length,
    // [30:23] data_byte, [31] zero
    output logic [ubxfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tuser,  // [0] has_data
    output logic                                  m_axis_tlast
);
    import ubxfr_pkg::*;

    ubxfr_cmd_t        cmd;
    ubxfr_status_t     status;
    logic [BYTE_W-1:0] msg_class;
    logic [BYTE_W-1:0] msg_id;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] data_byte;

    ubxfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ubxfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (s_axis_tdata),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .msg_class      (msg_class),
        .msg_id         (msg_id),
        .payload_length (payload_length),
        .has_data       (m_axis_tuser),
        .data_byte      (data_byte),
        .last           (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, data_byte, payload_length, msg_id, msg_class};

endmodule

[src/ubxfr_checker.sv]
`timescale 1ns / 1ps

module ubxfr_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [ubxfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input logic                                  m_axis_tuser,
    input logic                                  m_axis_tlast
);
    import ubxfr_pkg::*;

    // a stalled word holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // an empty frame is a single word
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[30:23] == '0))
        else $error("empty frame word not last or data not zero");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[22:16] != '0))
        else $error("data word with zero payload length");

    // input is held off while a frame is still being read out
    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during frame readout");

endmodule

bind ubx_frame_receiver_top ubxfr_checker u_ubxfr_checker (.*);

[bench/ubx_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps

module ubx_frame_receiver_top_tb;

    import ubxfr_pkg::*;

    localparam int MAX_PAY     = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int END_PAD     = 40;
    localparam int WHOLE       = 1 << 20;
    localparam int TIMEOUT_NS  = 5_000_000;

    localparam logic [7:0] SYNC1_SET [4] = '{8'h00, 8'hFF, 8'h5A, SYNC_FIRST_RST};
    localparam logic [7:0] SYNC2_SET [4] = '{8'hFF, 8'h00, 8'h5A, SYNC_SECOND_RST};

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum int {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_fault_t;

    typedef struct packed {
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [6:0] pay_len;
        logic       has_data;
        logic [7:0] data_byte;
        logic       last;
    } frame_word_t;

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [BYTE_W-1:0]       cfg_data      = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [BYTE_W-1:0]       s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    // shadow of the parser state and registers
    ubxfr_state_t rx_phase   = ST_SYNC1;
    logic [7:0]   sync1_cfg  = SYNC_FIRST_RST;
    logic [7:0]   sync2_cfg  = SYNC_SECOND_RST;
    logic [7:0]   frm_class  = '0;
    logic [7:0]   frm_id     = '0;
    logic [15:0]  frm_len    = '0;
    logic [6:0]   pay_cnt    = '0;
    logic [7:0]   fl_a       = '0;
    logic [7:0]   fl_b       = '0;
    logic [7:0]   ck_a_rx    = '0;
    logic [7:0]   pay_mem [MAX_PAY];

    frame_word_t  pending_words [$];
    int           words_predicted = 0;
    int           bytes_offered   = 0;
    int           mismatches      = 0;

    logic         calm      = 1'b0;
    int           hold_req  = 0;
    int           hold_ack  = 0;
    int           hold_left = 0;

    ubx_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAY)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[ubx_frame_receiver_top] ERROR");
        $finish;
    end

    // Advance the frame parser by one byte and queue any words it releases.
    task automatic absorb_byte(input logic [7:0] b);
        int k;
        frame_word_t w;
        case (rx_phase)
            ST_SYNC1:
            begin
                if (b == sync1_cfg)
                    rx_phase = ST_SYNC2;
            end
            ST_SYNC2:
            begin
                if (b == sync2_cfg)
                    rx_phase = ST_CLASS;
                else if (b == sync1_cfg)
                    rx_phase = ST_SYNC2;
                else
                    rx_phase = ST_SYNC1;
            end
            ST_CLASS:
            begin
                frm_class = b;
                fl_a      = b;
                fl_b      = b;
                rx_phase  = ST_ID;
            end
            ST_ID:
            begin
                frm_id   = b;
                fl_a     = fl_a + b;
                fl_b     = fl_b + fl_a;
                rx_phase = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                frm_len  = {8'h00, b};
                fl_a     = fl_a + b;
                fl_b     = fl_b + fl_a;
                rx_phase = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                frm_len[15:8] = b;
                fl_a          = fl_a + b;
                fl_b          = fl_b + fl_a;
                pay_cnt       = '0;
                if (frm_len > MAX_PAY)
                    rx_phase = ST_SYNC1;
                else if (frm_len == 0)
                    rx_phase = ST_CK_A;
                else
                    rx_phase = ST_PAYLOAD;
            end
            ST_PAYLOAD:
            begin
                pay_mem[pay_cnt[5:0]] = b;
                fl_a    = fl_a + b;
                fl_b    = fl_b + fl_a;
                pay_cnt = pay_cnt + 7'd1;
                if (16'(pay_cnt) >= frm_len)
                    rx_phase = ST_CK_A;
            end
            ST_CK_A:
            begin
                ck_a_rx  = b;
                rx_phase = ST_CK_B;
            end
            ST_CK_B:
            begin
                if (ck_a_rx == fl_a && b == fl_b)
                begin
                    w.msg_class = frm_class;
                    w.msg_id    = frm_id;
                    if (frm_len == 0)
                    begin
                        w.pay_len   = '0;
                        w.has_data  = 1'b0;
                        w.data_byte = '0;
                        w.last      = 1'b1;
                        pending_words = {pending_words, w};
                        words_predicted++;
                    end
                    else
                    begin
                        for (k = 0; k < int'(frm_len); k++)
                        begin
                            w.pay_len   = frm_len[6:0];
                            w.has_data  = 1'b1;
                            w.data_byte = pay_mem[k];
                            w.last      = (k == int'(frm_len) - 1);
                            pending_words = {pending_words, w};
                            words_predicted++;
                        end
                    end
                end
                rx_phase = ST_SYNC1;
            end
            default:
                rx_phase = ST_SYNC1;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 9)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_byte(b);
        bytes_offered++;
    endtask

    // Build a frame from the current sync values and send at most cut bytes of it.
    // An oversized length stops the frame after the header.
    task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input fill_t fill,
                              input ck_fault_t fault, input int cut);
        logic [7:0] fb [$];
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] pb;
        int n;
        fb = {sync1_cfg, sync2_cfg, cls, id, len[7:0], len[15:8]};
        sa = '0;
        sb = '0;
        for (n = 2; n < 6; n++)
        begin
            sa = sa + fb[n];
            sb = sb + sa;
        end
        if (len <= MAX_PAY)
        begin
            for (n = 0; n < int'(len); n++)
            begin
                if (fill == FILL_ZERO)
                    pb = 8'h00;
                else if (fill == FILL_ONES)
                    pb = 8'hFF;
                else
                    pb = 8'($urandom_range(0, 255));
                fb = {fb, pb};
                sa = sa + pb;
                sb = sb + sa;
            end
            if (fault == CK_BAD_A)
                sa = sa ^ 8'(1 << $urandom_range(0, 7));
            if (fault == CK_BAD_B)
                sb = sb ^ 8'(1 << $urandom_range(0, 7));
            fb = {fb, sa};
            fb = {fb, sb};
        end
        for (n = 0; n < fb.size() && n < cut; n++)
            send_byte(fb[n]);
    endtask

    // Drop valid and hold until every expected word has come out, then settle.
    task automatic wait_drain(input int pad);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
        repeat (pad) @(posedge clk);
    endtask

    task automatic write_sync_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SYNC_FIRST)
            sync1_cfg = val;
        else
            sync2_cfg = val;
    endtask

    task automatic test_frame_parsing;
        // repeated first sync keeps the parser waiting for the second
        send_byte(sync1_cfg);
        send_byte(sync1_cfg);
        push_frame(8'h00, 8'hFF, 16'd0, FILL_RANDOM, CK_GOOD, WHOLE);
        // second sync mismatch that is not a first sync either
        send_byte(sync1_cfg);
        send_byte(~sync2_cfg & ~sync1_cfg);
        push_frame(8'hFF, 8'h00, 16'd1, FILL_ONES, CK_GOOD, WHOLE);
        push_frame(8'h06, 8'h01, 16'd1, FILL_ZERO, CK_BAD_B, WHOLE);
        push_frame(8'h0A, 8'h04, 16'd0, FILL_RANDOM, CK_BAD_A, WHOLE);
        push_frame(8'h01, 8'h07, 16'd65, FILL_RANDOM, CK_GOOD, WHOLE);
        push_frame(8'h01, 8'h07, 16'hFFFF, FILL_RANDOM, CK_GOOD, WHOLE);
        push_frame(8'h02, 8'h15, 16'd2, FILL_RANDOM, CK_GOOD, WHOLE);
        wait_drain(SETTLE);
    endtask

    task automatic test_sync_settings;
        int s;
        for (s = 0; s < 4; s++)
        begin
            // leave the parser waiting on the second sync across the change
            send_byte(sync1_cfg);
            wait_drain(SETTLE);
            write_sync_reg(REG_SYNC_SECOND, SYNC2_SET[s]);
            write_sync_reg(REG_SYNC_FIRST, SYNC1_SET[s]);
            push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 4)), FILL_RANDOM, CK_GOOD, WHOLE);
            send_byte(8'($urandom_range(0, 255)));
            push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(1, 3)), FILL_RANDOM, CK_GOOD, WHOLE);
        end
        wait_drain(SETTLE);
    endtask

    task automatic test_output_backpressure;
        hold_req <= hold_req + 1;
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'(MAX_PAY), FILL_RANDOM, CK_GOOD, WHOLE);
        repeat (2)
            push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(1, 4)), FILL_RANDOM, CK_GOOD, WHOLE);
        wait_drain(SETTLE);
    endtask

    task automatic test_random_traffic;
        int start_bytes;
        int start_words;
        int iter;
        int pick;
        int r;
        int len;
        ck_fault_t fault;
        start_bytes = bytes_offered;
        start_words = words_predicted;
        iter = 0;
        calm <= 1'b1;
        while ((bytes_offered - start_bytes) < 30 || (words_predicted - start_words) < 10)
        begin
            iter++;
            if (iter == 5)
                calm <= 1'b0;
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 99);
            len  = (r < 80) ? $urandom_range(0, 8) :
                   (r < 96) ? $urandom_range(9, MAX_PAY - 1) : MAX_PAY;
            fault = ($urandom_range(0, 99) < 12) ? ck_fault_t'($urandom_range(1, 2)) : CK_GOOD;
            if (pick < 72)
            begin
                push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           16'(len), FILL_RANDOM, fault, WHOLE);
            end
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 92)
            begin
                // cut the frame short; the next frame may get swallowed as its tail
                len = $urandom_range(1, 8);
                push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           16'(len), FILL_RANDOM, CK_GOOD, $urandom_range(1, len + 7));
            end
            else
            begin
                push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           16'($urandom_range(MAX_PAY + 1, 16'hFFFF)), FILL_RANDOM,
                           CK_GOOD, WHOLE);
            end
        end
        calm <= 1'b0;
    endtask

    // Output side: long hold on request, otherwise random stalls unless calm.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        frame_word_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t ns: unexpected word, tdata 0x%08h tuser %0b tlast %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("msg_class", want.msg_class, m_axis_tdata[7:0]);
                check_field("msg_id", want.msg_id, m_axis_tdata[15:8]);
                check_field("payload_length", want.pay_len, m_axis_tdata[22:16]);
                check_field("has_data", want.has_data, m_axis_tuser);
                check_field("data_byte", want.data_byte, m_axis_tdata[30:23]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_frame_parsing();
        test_sync_settings();
        test_output_backpressure();
        test_random_traffic();
        wait_drain(END_PAD);
        if (mismatches == 0)
            $display("[ubx_frame_receiver_top] OK");
        else
            $display("[ubx_frame_receiver_top] ERROR");
        $finish;
    end

endmodule
